[rtl/ipv4v_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Types and character codes shared by the address string checker.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

  // scan phase of one string
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,  // leading slashes
    PH_ADDR  = 3'd1,  // dotted quad
    PH_GAP   = 3'd2,  // slashes after the address
    PH_MWS   = 3'd3,  // whitespace before the mask
    PH_MDIG  = 3'd4,  // mask digits
    PH_REST  = 3'd5,  // rest of the string ignored
    PH_ENDED = 3'd6   // ended by a nul byte
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [9:0] PART_MAX  = 10'd255;
  localparam logic [5:0] MASK_MAX  = 6'd32;
  localparam logic [5:0] MASK_SAT  = 6'd33;
  localparam logic [2:0] DOTS_NEED = 3'd3;
  localparam logic [2:0] PART_DIGS = 3'd3;

endpackage

[rtl/ipv4_prefix_string_validator.sv]
// ----------------------------------------------------------------------------
// ipv4_prefix_string_validator
// Checks a text address with prefix length ("a.b.c.d/len"), one byte per
// word, and reports one pass/fail word after the byte flagged is_last.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------
//  input    | in_valid / in_ready  | char_code[7:0], is_last
//  result   | out_valid / out_ready| valid_res
//
//  One byte per cycle sustained, but for the stall below: a byte is captured
//  in the input register, then the scan logic updates the string state or, on
//  the last byte, clears it and loads the result register.
//  The scan stage only stalls on a last byte while an earlier result is still
//  unread; other bytes pass regardless of the result side.
//  rst (synchronous) clears the string state and both valid flags.
// ----------------------------------------------------------------------------
module ipv4_prefix_string_validator #(
  parameter int MAX_LEN = 18
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       valid_res
);
  import ipv4v_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LEN);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_fire;

  // string state
  phase_t          phase, phase_next;
  logic [2:0]      dot_count, dot_count_next;
  logic [2:0]      run_digits, run_digits_next;
  logic [9:0]      part_value, part_value_next;
  logic [5:0]      mask_value, mask_value_next;
  logic            mask_negative, mask_negative_next;
  logic            failed, failed_next;
  logic [CntW-1:0] char_count, char_count_next;
  logic            result_next;

  // character classes
  logic       c_dig, c_ws, c_slash;
  logic [3:0] c_val;
  logic       do_addr, do_mstart;
  logic [8:0] mask_acc;

  assign c_dig   = (s1_char >= CH_ZERO) && (s1_char <= CH_NINE);
  assign c_ws    = (s1_char == CH_SPACE) || ((s1_char >= CH_TAB) && (s1_char <= CH_CR));
  assign c_slash = (s1_char == CH_SLASH);
  assign c_val   = s1_char[3:0];
  assign mask_acc = 9'(mask_value) * 9'd10 + 9'(c_val);

  // handshake
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // scan step for one byte
  always_comb begin
    phase_next         = phase;
    dot_count_next     = dot_count;
    run_digits_next    = run_digits;
    part_value_next    = part_value;
    mask_value_next    = mask_value;
    mask_negative_next = mask_negative;
    failed_next        = failed;
    char_count_next    = char_count;
    do_addr            = 1'b0;
    do_mstart          = 1'b0;
    result_next        = 1'b0;

    if (phase != PH_ENDED) begin
      if (s1_char == CH_NUL) begin
        if (phase < PH_MWS) failed_next = 1'b1;
        phase_next = PH_ENDED;
      end else begin
        if (char_count >= CntMax) failed_next = 1'b1;
        else char_count_next = char_count + CntW'(1);

        unique case (phase)
          PH_LEAD: begin
            if (!c_slash) begin
              phase_next = PH_ADDR;
              do_addr    = 1'b1;
            end
          end
          PH_ADDR: begin
            if (c_slash) begin
              if (run_digits == 3'd0 || part_value > PART_MAX) failed_next = 1'b1;
              if (dot_count != DOTS_NEED) failed_next = 1'b1;
              phase_next = PH_GAP;
            end else begin
              do_addr = 1'b1;
            end
          end
          PH_GAP: begin
            if (!c_slash) begin
              phase_next = PH_MWS;
              do_mstart  = 1'b1;
            end
          end
          PH_MWS: do_mstart = 1'b1;
          PH_MDIG: begin
            if (c_dig) begin
              if (mask_acc > 9'(MASK_SAT)) mask_value_next = MASK_SAT;
              else mask_value_next = mask_acc[5:0];
            end else begin
              phase_next = PH_REST;
            end
          end
          default: ;
        endcase

        // address byte
        if (do_addr) begin
          if (s1_char == CH_DOT) begin
            if (run_digits == 3'd0 || part_value > PART_MAX) failed_next = 1'b1;
            if (dot_count >= DOTS_NEED) failed_next = 1'b1;
            else dot_count_next = dot_count + 3'd1;
            run_digits_next = 3'd0;
            part_value_next = 10'd0;
          end else if (c_dig) begin
            if (run_digits >= PART_DIGS) begin
              failed_next = 1'b1;
            end else begin
              run_digits_next = run_digits + 3'd1;
              part_value_next = part_value * 10'd10 + 10'(c_val);
            end
          end else begin
            failed_next = 1'b1;
          end
        end

        // first byte of the mask token
        if (do_mstart) begin
          priority if (c_slash) begin
            phase_next = PH_REST;
          end else if (c_ws) begin
            phase_next = PH_MWS;
          end else if (s1_char == CH_PLUS) begin
            phase_next = PH_MDIG;
          end else if (s1_char == CH_MINUS) begin
            mask_negative_next = 1'b1;
            phase_next = PH_MDIG;
          end else if (c_dig) begin
            mask_value_next = {2'b00, c_val};
            phase_next = PH_MDIG;
          end else begin
            phase_next = PH_REST;
          end
        end
      end
    end

    // verdict on the last byte
    if (s1_last) begin
      result_next = !(failed_next || (phase_next < PH_MWS) ||
                      (mask_value_next > MASK_MAX) ||
                      (mask_negative_next && mask_value_next != 6'd0));
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char <= char_code;
      s1_last <= is_last;
    end
  end

  // string state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      dot_count     <= 3'd0;
      run_digits    <= 3'd0;
      part_value    <= 10'd0;
      mask_value    <= 6'd0;
      mask_negative <= 1'b0;
      failed        <= 1'b0;
      char_count    <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        phase         <= PH_LEAD;
        dot_count     <= 3'd0;
        run_digits    <= 3'd0;
        part_value    <= 10'd0;
        mask_value    <= 6'd0;
        mask_negative <= 1'b0;
        failed        <= 1'b0;
        char_count    <= '0;
      end else begin
        phase         <= phase_next;
        dot_count     <= dot_count_next;
        run_digits    <= run_digits_next;
        part_value    <= part_value_next;
        mask_value    <= mask_value_next;
        mask_negative <= mask_negative_next;
        failed        <= failed_next;
        char_count    <= char_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      valid_res <= result_next;
    end
  end

endmodule

[test/ipv4_prefix_string_validator_tb.sv]
// ----------------------------------------------------------------------------
// ipv4_prefix_string_validator_tb
// Feeds address strings ("a.b.c.d/len") one byte per word and checks every
// pass/fail word against a scan model kept inside the bench. A short
// directed set covers field limits, mask parsing, nul bytes, length limits
// and empty strings. Random well-formed, damaged and noise strings follow,
// with sender bursts and gaps against several receiver stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_prefix_string_validator_tb;
  import ipv4v_pkg::*;

  localparam int LEN_MAX     = 18;
  localparam int ITEM_GOAL   = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;

  // receiver stall patterns
  localparam logic [1:0] RX_OPEN   = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_SPARSE = 2'd2;
  localparam logic [1:0] RX_COMB   = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'd0;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       valid_res;

  // scan model state
  phase_t     sc_phase;
  logic [2:0] sc_dots;
  logic [2:0] sc_digs;
  logic [9:0] sc_part;
  logic [5:0] sc_mask;
  logic       sc_neg;
  logic       sc_bad;
  logic [4:0] sc_count;

  logic       verdict_q[$];
  logic [7:0] text_q[$];

  int fails = 0;
  int items_sent = 0;
  int lines_sent = 0;
  int verdicts_seen = 0;
  int verdicts_valid = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit gap_en = 1'b0;
  bit rx_auto = 1'b0;
  logic [1:0]  rx_mode = RX_OPEN;
  logic [15:0] rx_tick = 16'd0;

  ipv4_prefix_string_validator #(
    .MAX_LEN(LEN_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_code(char_code),
    .is_last  (is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .valid_res(valid_res)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scan model
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic scan_clear();
    sc_phase = PH_LEAD;
    sc_dots  = '0;
    sc_digs  = '0;
    sc_part  = '0;
    sc_mask  = '0;
    sc_neg   = 1'b0;
    sc_bad   = 1'b0;
    sc_count = '0;
  endtask

  // a part needs 1..3 digits and a value up to 255
  task automatic close_part();
    if (sc_digs == 0 || sc_part > PART_MAX) sc_bad = 1'b1;
  endtask

  task automatic addr_byte(input logic [7:0] c);
    if (c == CH_DOT) begin
      close_part();
      if (sc_dots >= DOTS_NEED) sc_bad = 1'b1;
      else sc_dots = sc_dots + 3'd1;
      sc_digs = '0;
      sc_part = '0;
    end else if (is_digit(c)) begin
      if (sc_digs >= PART_DIGS) begin
        sc_bad = 1'b1;
      end else begin
        sc_digs = sc_digs + 3'd1;
        sc_part = sc_part * 10'd10 + 10'(c - CH_ZERO);
      end
    end else begin
      sc_bad = 1'b1;
    end
  endtask

  // first byte of the mask token: whitespace, sign or digit; any other byte ends the mask
  task automatic mask_lead(input logic [7:0] c);
    if (c == CH_SLASH) begin
      sc_phase = PH_REST;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      sc_phase = PH_MWS;
    end else if (c == CH_PLUS) begin
      sc_phase = PH_MDIG;
    end else if (c == CH_MINUS) begin
      sc_neg   = 1'b1;
      sc_phase = PH_MDIG;
    end else if (is_digit(c)) begin
      sc_mask  = 6'(c - CH_ZERO);
      sc_phase = PH_MDIG;
    end else begin
      sc_phase = PH_REST;
    end
  endtask

  // advance the scan by one byte; the flagged byte yields a verdict
  task automatic scan_byte(input logic [7:0] c, input logic end_flag);
    int m;
    if (sc_phase != PH_ENDED) begin
      if (c == CH_NUL) begin
        if (sc_phase < PH_MWS) sc_bad = 1'b1;
        sc_phase = PH_ENDED;
      end else begin
        if (sc_count >= LEN_MAX) sc_bad = 1'b1;
        else sc_count = sc_count + 5'd1;
        case (sc_phase)
          PH_LEAD: begin
            if (c != CH_SLASH) begin
              sc_phase = PH_ADDR;
              addr_byte(c);
            end
          end
          PH_ADDR: begin
            if (c == CH_SLASH) begin
              close_part();
              if (sc_dots != DOTS_NEED) sc_bad = 1'b1;
              sc_phase = PH_GAP;
            end else begin
              addr_byte(c);
            end
          end
          PH_GAP: begin
            if (c != CH_SLASH) mask_lead(c);
          end
          PH_MWS: mask_lead(c);
          PH_MDIG: begin
            if (is_digit(c)) begin
              m = int'(sc_mask) * 10 + int'(c) - int'(CH_ZERO);
              sc_mask = (m > int'(MASK_SAT)) ? MASK_SAT : 6'(m);
            end else begin
              sc_phase = PH_REST;
            end
          end
          default: ;
        endcase
      end
    end
    if (end_flag) begin
      if (sc_phase < PH_MWS) sc_bad = 1'b1;
      if (sc_mask > MASK_MAX || (sc_neg && sc_mask != 0)) sc_bad = 1'b1;
      verdict_q.push_back(!sc_bad);
      scan_clear();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic end_flag);
    int gap;
    if (gap_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    char_code <= c;
    is_last   <= end_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(c, end_flag);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    text_q.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // decimal with optional zero padding to a given width
  task automatic push_num(input int v, input int digits);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < digits) s = {"0", s};
    push_text(s);
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    lines_sent++;
  endtask

  task automatic send_line(input string s);
    push_text(s);
    send_text_q();
  endtask

  // mostly well-formed address with random fields, prefix and tail
  task automatic build_quad_line();
    int r;
    int v;
    int pad;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_text("/");
    for (int p = 0; p < 4; p++) begin
      r = $urandom_range(0, 19);
      v = (r == 0) ? $urandom_range(256, 999) :
          (r == 1) ? $urandom_range(250, 255) : $urandom_range(0, 255);
      pad = (r == 2) ? 4 : ($urandom_range(0, 5) == 0) ? 3 : 0;
      push_num(v, pad);
      if (p < 3) push_text(".");
    end
    if ($urandom_range(0, 11) != 0) begin
      repeat (($urandom_range(0, 5) == 0) ? 2 : 1) push_text("/");
      if ($urandom_range(0, 5) == 0) push_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
      r = $urandom_range(0, 5);
      if (r == 0) push_byte(CH_MINUS);
      else if (r == 1) push_byte(CH_PLUS);
      r = $urandom_range(0, 9);
      v = (r == 0) ? $urandom_range(33, 999) : (r == 1) ? 0 : $urandom_range(0, 32);
      push_num(v, 0);
      if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // bytes biased toward the address alphabet
  task automatic build_noise_line();
    int r;
    repeat ($urandom_range(1, 24)) begin
      r = $urandom_range(0, 9);
      if (r < 4) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      else if (r < 6) push_byte(CH_DOT);
      else if (r == 6) push_byte(CH_SLASH);
      else if (r == 7) begin
        case ($urandom_range(0, 3))
          0: push_byte(CH_SPACE);
          1: push_byte(CH_MINUS);
          2: push_byte(CH_PLUS);
          default: push_byte(CH_TAB + 8'($urandom_range(0, 4)));
        endcase
      end else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // one random string: well-formed, damaged or noise
  task automatic send_random_line();
    int idx;
    if ($urandom_range(0, 4) == 0) build_noise_line();
    else build_quad_line();
    if ($urandom_range(0, 5) == 0) begin
      idx = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0: text_q[idx] = 8'($urandom_range(0, 255));
        1: text_q.insert(idx, CH_NUL);
        2: if (text_q.size() > 1) text_q.delete(idx);
        default: text_q.insert(idx, 8'($urandom_range(0, 255)));
      endcase
    end
    send_text_q();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (!rx_auto) rx_mode <= RX_OPEN;
    else if (rx_tick[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      RX_COMB:   out_ready <= (rx_tick[2:0] < 3'd3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("valid_res: word with no string pending, got %0d", valid_res);
        fails++;
      end else begin
        if (valid_res !== verdict_q[0]) begin
          $error("valid_res: expected %0d, got %0d", verdict_q[0], valid_res);
          fails++;
        end
        void'(verdict_q.pop_front());
      end
      verdicts_seen++;
      if (valid_res === 1'b1) verdicts_valid++;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ipv4_prefix_string_validator: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_address_fields();
    send_line("192.168.0.1/24");
    send_line("255.255.255.255/32");
    send_line("0.0.0.0/0");
    send_line("256.1.1.1/8");
    send_line("1.2.3/8");
    send_line("1.2.3.4.5/8");
    send_line("1..2.3/8");
    send_line("1234.1.1.1/8");
    send_line("1.2.a.4/8");
    send_line("//1.2.3.4//8");
    // high byte inside the address
    push_text("1.2.");
    push_byte(8'hff);
    push_text(".4/8");
    send_text_q();
  endtask

  task automatic test_mask_token();
    send_line("1.2.3.4");
    send_line("1.2.3.4//");
    send_line("1.2.3.4/ \t+7x");
    send_line("1.2.3.4/-0");
    send_line("1.2.3.4/-5");
    send_line("1.2.3.4/999");
    send_line("1.2.3.4/33");
    send_line("1.2.3.4/q");
    send_line("1.2.3.4/ /");
    // high byte after the mask digits is ignored
    push_text("1.2.3.4/8");
    push_byte(8'd200);
    send_text_q();
  endtask

  task automatic test_string_limits();
    // nul after the mask, then ignored bytes
    push_text("1.2.3.4/1");
    push_byte(CH_NUL);
    push_text("junk");
    send_text_q();
    // nul inside the address
    push_text("1.2");
    push_byte(CH_NUL);
    push_text(".3.4/8");
    send_text_q();
    send_line("///");
    send_line("/");
    push_byte(CH_NUL);
    send_text_q();
    send_line("10.20.30.40/0000032");
  endtask

  task automatic test_smooth_stream();
    gap_en  = 1'b0;
    rx_auto = 1'b0;
    while (items_sent < 300) send_random_line();
  endtask

  task automatic test_drain_pause();
    gap_en  = 1'b1;
    rx_auto = 1'b1;
    repeat (12) send_random_line();
    wait_drained();
    repeat (12) send_random_line();
  endtask

  task automatic test_bursty_stream();
    gap_en  = 1'b1;
    rx_auto = 1'b1;
    while (items_sent < ITEM_GOAL) send_random_line();
  endtask

  initial begin
    scan_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_address_fields();
    test_mask_token();
    test_string_limits();
    test_smooth_stream();
    test_drain_pause();
    test_bursty_stream();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("valid_res: %0d verdicts never arrived", verdict_q.size());
      fails += verdict_q.size();
    end
    $display("covered %0d bytes in %0d strings, %0d verdicts checked (%0d valid)",
             items_sent, lines_sent, verdicts_seen, verdicts_valid);
    $display("sender bursts and gaps ran against open, random and patterned receiver stalls");
    if (fails == 0) begin
      $display("ipv4_prefix_string_validator: match");
    end else begin
      $display("ipv4_prefix_string_validator: mismatch");
    end
    $finish;
  end

endmodule
